/* sv/flpt_pkg.sv */
// Shared types, constants and codes for the four-level page table walker.
`default_nettype none
package flpt_pkg;
  localparam int TablePagesDefault = 64;
  localparam int IndexBits = 9;
  localparam int EntPerPage = 1 << IndexBits;
  localparam int CfgAddrBits = 5;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusLarge   = 2'd1;
  localparam logic [1:0] StatusNoPages = 2'd2;
  localparam logic [1:0] StatusOutside = 2'd3;

  localparam logic CmdMap    = 1'b0;
  localparam logic CmdLookup = 1'b1;

  localparam logic [CfgAddrBits-1:0] RegStoreBase = 5'h00;
  localparam logic [CfgAddrBits-1:0] RegRootPage  = 5'h08;
  localparam logic [CfgAddrBits-1:0] RegFirstFree = 5'h10;

  typedef struct packed {
    logic        cmd;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [63:0] flags;
  } flpt_req_t;

  typedef struct packed {
    logic [51:0] result_addr;
    logic        found;
    logic [1:0]  status;
  } flpt_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_DECIDE, ST_ZERO, ST_DONE
  } flpt_state_t;
endpackage
`default_nettype wire

/* sv/four_level_page_table_walker.sv */
// Top level of the four-level page table walker: config registers, front and back ends.
`default_nettype none
// Maps or looks up 48-bit virtual addresses in a local store of TablePages
// pages of 512 64-bit entries. A request is taken when in_start is high and
// in_busy is low; one result per request appears on out_* for a single cycle
// under out_strobe and cannot be held off. After reset the store is cleared
// one entry a cycle with in_busy high. A lookup makes up to four table
// reads, each through READ, WAIT and DECIDE; a map also clears all 512
// entries of every new table it allocates. Requests queue two deep ahead
// of the walker. Write config only when idle; registers sit at byte
// addresses 0, 8 and 16 on a 64-bit data path.
module four_level_page_table_walker #(
  parameter int TablePages = flpt_pkg::TablePagesDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_start,
  output logic                               in_busy,
  input  wire flpt_pkg::flpt_req_t           in_req,
  output logic                               out_strobe,
  output flpt_pkg::flpt_res_t                out_res,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [flpt_pkg::CfgAddrBits-1:0] cfg_paddr,
  input  wire logic [63:0]                   cfg_pwdata,
  output logic [63:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import flpt_pkg::*;
  logic [51:0] base_r;
  logic [5:0]  root_r;
  logic [6:0]  ffree_r;
  logic wr, full, pop, avail, clearing, reload;
  flpt_req_t head;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign reload = wr && cfg_paddr == RegFirstFree;
  // Hold off requests while the queue is full or the store is being cleared.
  assign in_busy = full || clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0; root_r <= '0; ffree_r <= 7'd1;
    end else if (wr) begin
      case (cfg_paddr)
        RegStoreBase: base_r  <= cfg_pwdata[51:0];
        RegRootPage:  root_r  <= cfg_pwdata[5:0];
        RegFirstFree: ffree_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      RegStoreBase: cfg_prdata = {12'h0, base_r};
      RegRootPage:  cfg_prdata = {58'h0, root_r};
      RegFirstFree: cfg_prdata = {57'h0, ffree_r};
      default:      cfg_prdata = '0;
    endcase
  end

  flpt_front u_front (
    .clk, .rst_n, .in_valid(in_start && !clearing), .in_req, .full,
    .pop, .avail, .head
  );

  // Reload the allocator straight from the write data on the access edge.
  flpt_back #(.TablePages(TablePages)) u_back (
    .clk, .rst_n, .avail, .head, .pop, .store_base(base_r), .root_page(root_r),
    .reload, .first_free(cfg_pwdata[6:0]), .out_valid(out_strobe), .out_res, .clearing
  );

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_busy) else $error("request taken during clear");
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe held");
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.found |-> out_res.status == StatusOk)
    else $error("found with error status");
endmodule
`default_nettype wire

/* sv/flpt_front.sv */
// Front end: takes requests and holds them in a short queue.
`default_nettype none
module flpt_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire flpt_pkg::flpt_req_t in_req,
  output logic                    full,
  input  wire logic               pop,
  output logic                    avail,
  output flpt_pkg::flpt_req_t     head
);
  import flpt_pkg::*;
  flpt_req_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic push;

  assign push  = in_valid && !full;
  assign full  = cnt_r == 2'd2;
  assign avail = cnt_r != 2'd0;
  assign head  = q_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop && avail};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop && avail) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_req;
  end
endmodule
`default_nettype wire

/* sv/flpt_back.sv */
// Back end: walks the tables in the store memory, allocates and clears new tables.
`default_nettype none
module flpt_back #(
  parameter int TablePages = flpt_pkg::TablePagesDefault,
  localparam int PgBits = $clog2(TablePages),
  localparam int MemBits = PgBits + flpt_pkg::IndexBits,
  localparam int CntBits = ($clog2(TablePages + 1) > 7) ? $clog2(TablePages + 1) : 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                avail,
  input  wire flpt_pkg::flpt_req_t head,
  output logic                     pop,
  input  wire logic [51:0]         store_base,
  input  wire logic [5:0]          root_page,
  input  wire logic                reload,
  input  wire logic [6:0]          first_free,
  output logic                     out_valid,
  output flpt_pkg::flpt_res_t      out_res,
  output logic                     clearing
);
  import flpt_pkg::*;
  localparam int MemDepth = TablePages * EntPerPage;

  logic [63:0] mem [MemDepth];
  logic [63:0] rd_r;
  logic        we;
  logic [MemBits-1:0] waddr, raddr;
  logic [63:0] wdata;

  flpt_state_t st_r, st_nxt;
  flpt_req_t   req_r;
  logic [1:0]  lvl_r, lvl_nxt;
  logic [PgBits-1:0] page_r, page_nxt;
  logic [CntBits-1:0] free_r, free_nxt;
  logic [MemBits:0] clr_r, clr_nxt;
  logic [IndexBits-1:0] zi_r, zi_nxt;
  flpt_res_t res_r, res_nxt;
  logic [IndexBits-1:0] idx;
  logic [51:0] off;
  logic [39:0] pg_full;
  logic [51:0] new_addr;
  logic root_bad;

  always_comb begin
    case (lvl_r)
      2'd0:    idx = req_r.virt_addr[47:39];
      2'd1:    idx = req_r.virt_addr[38:30];
      2'd2:    idx = req_r.virt_addr[29:21];
      default: idx = req_r.virt_addr[20:12];
    endcase
  end

  assign off      = {rd_r[51:12], 12'h0} - {store_base[51:12], 12'h0};
  assign pg_full  = off[51:12];
  assign new_addr = store_base + {free_r[PgBits-1:0], 12'h0};
  assign root_bad = {26'h0, root_page} >= 32'(TablePages);
  assign raddr    = {page_r, idx};
  assign clearing = st_r == ST_CLEAR;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR:  if (clr_r == MemBits'(MemDepth - 1) + (MemBits+1)'(0)) st_nxt = ST_IDLE;
      ST_IDLE:   if (avail) st_nxt = ST_READ;
      ST_READ:   st_nxt = root_bad && lvl_r == 2'd0 && res_r.status == StatusOutside
                          ? ST_DONE : ST_WAIT;
      ST_WAIT:   st_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (lvl_r == 2'd3) st_nxt = ST_DONE;
        else if (!rd_r[0]) begin
          if (req_r.cmd == CmdLookup || free_r >= CntBits'(TablePages)) st_nxt = ST_DONE;
          else st_nxt = ST_ZERO;
        end else if (rd_r[7] || pg_full >= 40'(TablePages)) st_nxt = ST_DONE;
        else st_nxt = ST_READ;
      end
      ST_ZERO:   if (zi_r == '1) st_nxt = ST_READ;
      ST_DONE:   st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0; waddr = raddr; wdata = '0;
    pop = 1'b0;
    lvl_nxt = lvl_r; page_nxt = page_r; free_nxt = free_r;
    clr_nxt = clr_r; zi_nxt = zi_r; res_nxt = res_r;
    if (reload) free_nxt = CntBits'(first_free);
    case (st_r)
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_r[MemBits-1:0]; clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        pop = avail; lvl_nxt = 2'd0; page_nxt = PgBits'(root_page);
        res_nxt = '{result_addr: '0, found: 1'b0,
                    status: root_bad ? StatusOutside : StatusOk};
      end
      ST_DECIDE: begin
        if (lvl_r == 2'd3) begin
          if (req_r.cmd == CmdMap) begin
            we = 1'b1;
            wdata = {12'h0, req_r.phys_addr[51:12], 12'h0} | 64'h1 | req_r.flags;
            res_nxt.found = 1'b1;
          end else if (rd_r[0]) begin
            res_nxt.found = 1'b1;
            res_nxt.result_addr = {rd_r[51:12], 12'h0};
          end
        end else if (!rd_r[0]) begin
          if (req_r.cmd == CmdMap) begin
            if (free_r >= CntBits'(TablePages)) res_nxt.status = StatusNoPages;
            else begin
              we = 1'b1;
              wdata = {12'h0, new_addr[51:12], 12'h0} | 64'h3;
              page_nxt = free_r[PgBits-1:0];
              free_nxt = free_r + 1'b1;
              zi_nxt = '0;
              lvl_nxt = lvl_r + 2'd1;
            end
          end
        end else if (rd_r[7]) res_nxt.status = StatusLarge;
        else if (pg_full >= 40'(TablePages)) res_nxt.status = StatusOutside;
        else begin
          page_nxt = pg_full[PgBits-1:0];
          lvl_nxt = lvl_r + 2'd1;
        end
      end
      ST_ZERO: begin
        we = 1'b1; waddr = {page_r, zi_r}; zi_nxt = zi_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; free_r <= CntBits'(1);
      lvl_r <= '0; zi_r <= '0; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; free_r <= free_nxt;
      lvl_r <= lvl_nxt; zi_r <= zi_nxt;
      out_valid <= st_r == ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && avail) req_r <= head;
    page_r <= page_nxt;
    res_r  <= res_nxt;
    if (st_r == ST_DONE) out_res <= res_r;
  end
endmodule
`default_nettype wire

/* tb/sv/flpt_checker.sv */
// Checker for the page table walker: shadows the table store and compares every result.
`default_nettype none
module flpt_checker #(
  parameter int TablePages = flpt_pkg::TablePagesDefault
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_start,
  input  wire logic                             in_busy,
  input  wire flpt_pkg::flpt_req_t              in_req,
  input  wire logic                             out_strobe,
  input  wire flpt_pkg::flpt_res_t              out_res,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [flpt_pkg::CfgAddrBits-1:0] cfg_paddr,
  input  wire logic [63:0]                      cfg_pwdata,
  input  wire logic                             cfg_pready,
  output int                                    fail_count,
  output int                                    pending_results
);
  import flpt_pkg::*;

  localparam logic [63:0] AddrMask = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] EntPresent = 64'h1;
  localparam logic [63:0] EntWritable = 64'h2;
  localparam logic [63:0] EntLarge = 64'h80;

  logic [63:0] shadow_store [TablePages*EntPerPage];
  logic [51:0] base_addr;
  int          root_pg;
  int          alloc_next;
  flpt_res_t   walk_results [$];

  // Page of the store that an entry points at, TablePages if outside.
  function automatic int store_page(logic [63:0] entry);
    logic [51:0] off;
    off = entry[51:0] & AddrMask[51:0];
    off = off - (base_addr & AddrMask[51:0]);
    if (off[51:12] >= TablePages) return TablePages;
    return int'(off[51:12]);
  endfunction

  function automatic flpt_res_t walk_table(flpt_req_t r);
    flpt_res_t   res;
    int          pg, np, ix;
    logic [8:0]  idx [4];
    logic [63:0] ent;
    res = '0;
    idx[0] = r.virt_addr[47:39];
    idx[1] = r.virt_addr[38:30];
    idx[2] = r.virt_addr[29:21];
    idx[3] = r.virt_addr[20:12];
    pg = root_pg;
    if (pg >= TablePages) begin
      res.status = StatusOutside;
      return res;
    end
    for (int lvl = 0; lvl < 3; lvl++) begin
      ix = pg * EntPerPage + idx[lvl];
      ent = shadow_store[ix];
      if (!ent[0]) begin
        if (r.cmd == CmdLookup) return res;
        if (alloc_next >= TablePages) begin
          res.status = StatusNoPages;
          return res;
        end
        np = alloc_next;
        alloc_next++;
        shadow_store[ix] = (({12'd0, base_addr} + 64'(np) * 64'h1000) & AddrMask)
                           | EntPresent | EntWritable;
        for (int k = 0; k < EntPerPage; k++) shadow_store[np*EntPerPage + k] = '0;
        pg = np;
      end else if (ent & EntLarge) begin
        res.status = StatusLarge;
        return res;
      end else begin
        pg = store_page(ent);
        if (pg >= TablePages) begin
          res.status = StatusOutside;
          return res;
        end
      end
    end
    ix = pg * EntPerPage + idx[3];
    if (r.cmd == CmdMap) begin
      shadow_store[ix] = ({12'd0, r.phys_addr} & AddrMask) | EntPresent | r.flags;
      res.found = 1'b1;
    end else if (shadow_store[ix][0]) begin
      res.result_addr = shadow_store[ix][51:0] & AddrMask[51:0];
      res.found = 1'b1;
    end
    return res;
  endfunction

  assign pending_results = walk_results.size();

  always @(posedge clk) begin
    flpt_res_t want;
    if (!rst_n) begin
      for (int k = 0; k < TablePages*EntPerPage; k++) shadow_store[k] = '0;
      base_addr = '0;
      root_pg = 0;
      alloc_next = 1;
      walk_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          RegStoreBase: base_addr = cfg_pwdata[51:0];
          RegRootPage:  root_pg = int'(cfg_pwdata[5:0]);
          RegFirstFree: alloc_next = int'(cfg_pwdata[6:0]);
          default: ;
        endcase
      end
      if (in_start && !in_busy) walk_results.push_back(walk_table(in_req));
      if (out_strobe) begin
        if (walk_results.size() == 0) begin
          $display("%0t result with nothing expected: %p", $time, out_res);
          fail_count <= fail_count + 1;
        end else begin
          want = walk_results.pop_front();
          if (want !== out_res) begin
            $display("%0t mismatch expected %p actual %p", $time, want, out_res);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench top: drives requests and config writes into the walker and gives the verdict.
`default_nettype none
module tb_top;
  import flpt_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_start = 1'b0;
  logic                   in_busy;
  flpt_req_t              in_req = '0;
  logic                   out_strobe;
  flpt_res_t              out_res;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CfgAddrBits-1:0] cfg_paddr = '0;
  logic [63:0]            cfg_pwdata = '0;
  logic [63:0]            cfg_prdata;
  logic                   cfg_pready;
  int                     fail_count;
  int                     pending_results;

  // Recently used virtual addresses, so lookups and remaps hit existing tables.
  logic [47:0] used_vas [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  four_level_page_table_walker dut (.*);

  flpt_checker chk (.*);

  // Setup then access phase; the register takes the value on the access edge.
  task automatic cfg_write(logic [CfgAddrBits-1:0] addr, logic [63:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Hold the request until the walker takes it; in_start stays high meanwhile
  // and may be dropped by the gap or drain that follows.
  task automatic send_request(flpt_req_t r);
    in_start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_busy) @(posedge clk);
  endtask

  // Drop the start line for a random gap: mostly short, a few long.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n != 0) begin
      in_start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop the start line and wait for every accepted request's result.
  task automatic wait_drained();
    in_start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_va();
    logic [47:0] va;
    va = {$urandom(), $urandom()};
    if (used_vas.size() != 0 && $urandom_range(0, 3) != 0) begin
      // Share the upper levels with a known address so walks go deep.
      va = used_vas[$urandom_range(0, used_vas.size() - 1)];
      case ($urandom_range(0, 3))
        0: ;
        1: va[20:12] = 9'($urandom());
        2: va[29:12] = 18'($urandom());
        default: va[38:12] = 27'($urandom());
      endcase
    end
    return va;
  endfunction

  function automatic flpt_req_t rand_request();
    flpt_req_t r;
    r.cmd = $urandom_range(0, 1) ? CmdLookup : CmdMap;
    r.virt_addr = rand_va();
    r.phys_addr = {$urandom(), $urandom()};
    r.flags = {$urandom(), $urandom()};
    // Keep most leaves small so the large-page bit appears mostly on purpose.
    if ($urandom_range(0, 3) != 0) r.flags = r.flags & 64'hffff_0000_0000_0f7e;
    return r;
  endfunction

  task automatic issue(flpt_req_t r);
    send_request(r);
    if (r.cmd == CmdMap && used_vas.size() < 64) used_vas.push_back(r.virt_addr);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      issue(rand_request());
      idle_gap();
    end
  endtask

  initial begin
    flpt_req_t r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of address and flags, lookups hit and miss.
    r = '{cmd: CmdMap, virt_addr: '0, phys_addr: '1, flags: '0};
    issue(r);
    r = '{cmd: CmdLookup, virt_addr: '0, phys_addr: '0, flags: '0};
    issue(r);
    r = '{cmd: CmdMap, virt_addr: '1, phys_addr: '0, flags: '1};
    issue(r);
    r = '{cmd: CmdLookup, virt_addr: '1, phys_addr: '1, flags: '1};
    issue(r);
    r = '{cmd: CmdLookup, virt_addr: 48'h5555_5555_5000, phys_addr: '0, flags: '0};
    issue(r);
    // Leaf carrying the large-page flag is still a plain leaf.
    r = '{cmd: CmdMap, virt_addr: 48'h0000_0020_1000, phys_addr: 52'h12345000,
          flags: 64'h80};
    issue(r);
    issue('{cmd: CmdLookup, virt_addr: 48'h0000_0020_1000, phys_addr: '0, flags: '0});
    // A large-page bit in a leaf entry: map it as a leaf, then look it up.
    issue('{cmd: CmdMap, virt_addr: 48'h0000_0000_0000, phys_addr: 52'h7000,
            flags: 64'h81});
    issue('{cmd: CmdLookup, virt_addr: 48'h0000_0000_0000, phys_addr: '0, flags: '0});
    wait_drained();

    // Leaf mapped to an address outside the store, and the last page as root.
    issue('{cmd: CmdMap, virt_addr: 48'h0000_0000_0000, phys_addr: 52'hfff_ffff_f000,
            flags: '0});
    wait_drained();
    cfg_write(RegRootPage, 64'd63);
    cfg_write(RegStoreBase, 64'h000f_ffff_fffc_0000);
    issue('{cmd: CmdLookup, virt_addr: 48'h1234_5678_9000, phys_addr: '0, flags: '0});
    wait_drained();
    cfg_write(RegStoreBase, 64'h0);
    issue('{cmd: CmdLookup, virt_addr: '1, phys_addr: '0, flags: '0});
    issue('{cmd: CmdMap, virt_addr: 48'hf000_0000_0000, phys_addr: 52'h9000, flags: '0});
    wait_drained();

    // Allocator exhaustion: an empty allocator, then two pages left.
    cfg_write(RegFirstFree, 64'd64);
    issue('{cmd: CmdMap, virt_addr: 48'h8000_0000_0000, phys_addr: 52'h1000, flags: '0});
    wait_drained();
    cfg_write(RegFirstFree, 64'd62);
    issue('{cmd: CmdMap, virt_addr: 48'h4000_0000_0000, phys_addr: 52'h2000, flags: '0});
    issue('{cmd: CmdLookup, virt_addr: 48'h4000_0000_0000, phys_addr: '0, flags: '0});
    wait_drained();

    // Random phases under several register settings, drained between them.
    used_vas.delete();
    cfg_write(RegRootPage, 64'd0);
    cfg_write(RegFirstFree, 64'd1);
    cfg_write(RegStoreBase, 64'h0);
    run_random(150);
    wait_drained();

    used_vas.delete();
    cfg_write(RegStoreBase, 64'h000f_ffff_ffff_f000);
    cfg_write(RegRootPage, 64'd5);
    cfg_write(RegFirstFree, 64'd6);
    run_random(130);
    wait_drained();

    // Root page overlapping the allocator range: self-overlap clears the root.
    used_vas.delete();
    cfg_write(RegStoreBase, {12'd0, 32'h00ab_cdef, 20'h0} & 64'h000f_ffff_ffff_f000);
    cfg_write(RegRootPage, 64'd40);
    cfg_write(RegFirstFree, 64'd40);
    run_random(130);
    wait_drained();

    used_vas.delete();
    cfg_write(RegStoreBase, 64'h0);
    cfg_write(RegRootPage, 64'd2);
    cfg_write(RegFirstFree, 64'd0);
    run_random(120);
    wait_drained();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far beyond the slowest run, with the reset clear and maps that clear new tables.
  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
